### hdl/greedy_column_balancer_macros.svh
// greedy column balancer: assertion macros shared by the checker
// depends on a clk and an arst_n in the scope where a macro is used
`ifndef GREEDY_COLUMN_BALANCER_MACROS_SVH
`define GREEDY_COLUMN_BALANCER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define GCB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define GCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/gcb_pkg.sv
// greedy column balancer: shared widths, codes and structs
// no dependencies
`timescale 1ns / 1ps

package gcb_pkg;

	// field widths
	localparam int RANK_W = 6;
	localparam int ELEM_W = 32;
	localparam int COL_W  = 20;
	localparam int SIZE_W = 13;
	localparam int CNT_W  = 7;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// operation codes
	localparam logic OP_GREEDY = 1'b0;
	localparam logic OP_PINNED = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_RANKS = 1'b0;
	localparam logic [CNT_W-1:0] NUM_RANKS_RESET = 7'd1;

	// load memory access from the sequencer
	typedef struct packed {
		logic              we;
		logic [RANK_W-1:0] addr;
		logic [ELEM_W-1:0] elem;
		logic [COL_W-1:0]  col;
	} mem_req_t;

	// registered load read data
	typedef struct packed {
		logic [ELEM_W-1:0] elem;
		logic [COL_W-1:0]  col;
	} mem_rsp_t;

endpackage

### hdl/gcb_in_if.sv
// greedy column balancer: input item channel
// depends on gcb_pkg
`timescale 1ns / 1ps

interface gcb_in_if import gcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [SIZE_W-1:0] column_size;
	logic [RANK_W-1:0] pinned_rank;

	modport source (output valid, output operation, output column_size,
		output pinned_rank, input ready);
	modport sink (input valid, input operation, input column_size,
		input pinned_rank, output ready);
endinterface

### hdl/gcb_out_if.sv
// greedy column balancer: result item channel
// depends on gcb_pkg
`timescale 1ns / 1ps

interface gcb_out_if import gcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] assigned_rank;
	logic [ELEM_W-1:0] rank_element_total;
	logic [COL_W-1:0]  rank_column_total;

	modport source (output valid, output assigned_rank, output rank_element_total,
		output rank_column_total, input ready);
	modport sink (input valid, input assigned_rank, input rank_element_total,
		input rank_column_total, output ready);
endinterface

### hdl/greedy_column_balancer.sv
// greedy column balancer top level: register port, load memory and sequencer
// item path: pinned item goes FETCH then UPDATE, greedy item goes SCAN over the n active ranks, FETCH, UPDATE
// one item at a time: a new item is accepted only in IDLE, once the last one has left UPDATE
// the greedy path is paced by the min scan, one load memory read per rank per cycle
// reset clears all loads, the round mask and sets num_ranks to 1; no clearing pass
// depends on gcb_pkg, gcb_in_if, gcb_out_if, gcb_load_mem, gcb_ctrl
`timescale 1ns / 1ps

module greedy_column_balancer import gcb_pkg::*; #(
	parameter int MAX_RANKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gcb_in_if.sink            req,
	gcb_out_if.source         rsp
);

	localparam int DEPTH = (MAX_RANKS < 64) ? MAX_RANKS : 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CNT_W-1:0] num_ranks_q;
	logic [CNT_W-1:0] act_cnt;
	mem_req_t         mem_req;
	mem_rsp_t         mem_rsp;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranks_q <= NUM_RANKS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_RANKS)) begin
			num_ranks_q <= pwdata[CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NUM_RANKS) ? DATA_W'(num_ranks_q) : '0;

	// active rank count clamped to 1..DEPTH
	always_comb begin
		if (num_ranks_q == '0) begin
			act_cnt = CNT_W'(1);
		end else if (num_ranks_q > CNT_W'(DEPTH)) begin
			act_cnt = CNT_W'(DEPTH);
		end else begin
			act_cnt = num_ranks_q;
		end
	end

	gcb_load_mem #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	gcb_ctrl #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.act_cnt (act_cnt),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

endmodule

### hdl/gcb_load_mem.sv
// greedy column balancer: per-rank element and column load memory
// one shared read/write address, registered read, valid bits cleared by reset; uses gcb_pkg
`timescale 1ns / 1ps

module gcb_load_mem import gcb_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [ELEM_W-1:0] elem_mem [DEPTH];
	logic [COL_W-1:0]  col_mem  [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [ELEM_W-1:0] rd_elem_q;
	logic [COL_W-1:0]  rd_col_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  idx;

	assign idx = req.addr[IDX_W-1:0];

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			elem_mem[idx] <= req.elem;
			col_mem[idx]  <= req.col;
		end
		rd_elem_q <= elem_mem[idx];
		rd_col_q  <= col_mem[idx];
	end

	// valid bits, an entry never written reads as zero load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[idx] <= 1'b1;
			end
			rd_vld_q <= vld_q[idx];
		end
	end

	assign rsp.elem = rd_vld_q ? rd_elem_q : '0;
	assign rsp.col  = rd_vld_q ? rd_col_q : '0;

endmodule

### hdl/gcb_ctrl.sv
// greedy column balancer: sequencer with shared min-compare and saturating update
// drives gcb_load_mem, holds the round mask and result register; uses gcb_pkg, gcb_in_if, gcb_out_if
`timescale 1ns / 1ps

module gcb_ctrl import gcb_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] act_cnt,
	gcb_in_if.sink           req,
	gcb_out_if.source        rsp,
	output mem_req_t         mem_req,
	input  mem_rsp_t         mem_rsp
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_UPDATE = 4'b1000
	} gcb_state_t;

	gcb_state_t        state_q;
	logic              op_q;
	logic [SIZE_W-1:0] size_q;
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] iss_q;
	logic              iss_done_q;
	logic              pend_s1;
	logic [RANK_W-1:0] idx_s1;
	logic              found_q;
	logic [ELEM_W-1:0] best_q;
	logic [DEPTH-1:0]  free_q;
	logic              out_valid_q;
	logic [RANK_W-1:0] out_rank_q;
	logic [ELEM_W-1:0] out_elem_q;
	logic [COL_W-1:0]  out_col_q;

	logic [DEPTH-1:0]  amask;
	logic [RANK_W-1:0] last_rank;
	logic [RANK_W-1:0] pin_rank;
	logic              accept;
	logic              upd_fire;
	logic              cand;
	logic              better;
	logic [ELEM_W:0]   sum;
	logic [ELEM_W-1:0] new_elem;
	logic [COL_W-1:0]  new_col;

	// active rank mask and clamped ranks
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			amask[i] = (CNT_W'(i) < act_cnt);
		end
	end
	assign last_rank = RANK_W'(act_cnt - CNT_W'(1));
	assign pin_rank  = ({1'b0, req.pinned_rank} < act_cnt) ? req.pinned_rank : last_rank;

	assign accept   = (state_q == ST_IDLE) && req.valid;
	assign upd_fire = (state_q == ST_UPDATE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE);

	// shared compare: candidate still free in the round and strictly lighter
	assign cand   = free_q[idx_s1[IDX_W-1:0]];
	assign better = cand && (!found_q || (mem_rsp.elem < best_q));

	// saturating update of the chosen rank
	assign sum      = {1'b0, mem_rsp.elem} + (ELEM_W + 1)'(size_q);
	assign new_elem = sum[ELEM_W] ? '1 : sum[ELEM_W-1:0];
	assign new_col  = (mem_rsp.col == '1) ? mem_rsp.col : mem_rsp.col + COL_W'(1);

	// load memory access
	assign mem_req.we   = upd_fire;
	assign mem_req.addr = (state_q == ST_SCAN) ? iss_q : rank_q;
	assign mem_req.elem = new_elem;
	assign mem_req.col  = new_col;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= '0;
			iss_done_q  <= 1'b0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded on update, emptied when taken
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_done_q <= 1'b0;
						pend_s1    <= 1'b0;
						found_q    <= 1'b0;
						if (req.operation == OP_PINNED) begin
							state_q <= ST_FETCH;
						end else begin
							// refill the round once no active rank is free
							if ((free_q & amask) == '0) begin
								free_q <= amask;
							end
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					pend_s1 <= !iss_done_q;
					if (iss_q == last_rank) begin
						iss_done_q <= 1'b1;
					end
					if (pend_s1 && better) begin
						found_q <= 1'b1;
					end
					if (pend_s1 && (idx_s1 == last_rank)) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_fire) begin
						if (op_q == OP_GREEDY) begin
							free_q[rank_q[IDX_W-1:0]] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields, scan pointers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			size_q <= req.column_size;
			rank_q <= pin_rank;
			iss_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= iss_q;
			if (!iss_done_q && (iss_q != last_rank)) begin
				iss_q <= iss_q + RANK_W'(1);
			end
			if (pend_s1 && better) begin
				best_q <= mem_rsp.elem;
				rank_q <= idx_s1;
			end
		end
		if (upd_fire) begin
			out_rank_q <= rank_q;
			out_elem_q <= new_elem;
			out_col_q  <= new_col;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.assigned_rank      = out_rank_q;
	assign rsp.rank_element_total = out_elem_q;
	assign rsp.rank_column_total  = out_col_q;

endmodule

### hdl/gcb_chk.sv
// greedy column balancer: port-level checker and its bind to the top level
// depends on gcb_pkg and greedy_column_balancer_macros.svh
`timescale 1ns / 1ps
`include "greedy_column_balancer_macros.svh"

module gcb_chk import gcb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [RANK_W-1:0] rsp_rank,
	input logic [ELEM_W-1:0] rsp_elem,
	input logic [COL_W-1:0]  rsp_col
);

	// a stalled result item holds
	`GCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rank) && $stable(rsp_elem) && $stable(rsp_col), "result item changed while stalled")

	// a delivered item always counts at least its own column
	`GCB_ASSERT_SAME(a_col_nonzero, rsp_valid, rsp_col != '0, "column total of zero")

	// one item at a time: busy right after an accept
	`GCB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready right after accept")

	// no result can appear the cycle after an accept
	`GCB_ASSERT_NEXT(a_min_latency, req_valid && req_ready, !$rose(rsp_valid), "result too early")

endmodule

bind greedy_column_balancer gcb_chk u_gcb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_rank  (rsp.assigned_rank),
	.rsp_elem  (rsp.rank_element_total),
	.rsp_col   (rsp.rank_column_total)
);
